[rtl/sync_word_length_deframer_macros.svh]
// Assertion macros for the sync word length deframer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SYNC_WORD_LENGTH_DEFRAMER_MACROS_SVH
`define SYNC_WORD_LENGTH_DEFRAMER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SWLD_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define SWLD_ASSERT_NEXT(lbl, clk, rstn, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) else $error(msg);

`endif

[rtl/swld_pkg.sv]
// Shared types and constants for the sync word length deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package swld_pkg;

    localparam int BUFFER_BYTES = 2048;
    localparam int HEADER_BYTES = 8;
    localparam int CRC_BYTES    = 4;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = 12;
    localparam int IDX_W        = 11;
    localparam int MAXLEN_W     = 11;
    localparam int LEN_HI_POS   = 5;
    localparam int LEN_LO_POS   = 6;
    localparam int SYNC_BYTES   = 4;

    localparam logic [MAXLEN_W-1:0] MAX_PAYLOAD_RESET = 11'd2036;

    localparam logic [7:0] SYNC_B0 = 8'h4D;  // 'M'
    localparam logic [7:0] SYNC_B1 = 8'h46;  // 'F'
    localparam logic [7:0] SYNC_B2 = 8'h50;  // 'P'
    localparam logic [7:0] SYNC_B3 = 8'h31;  // '1'

    typedef enum logic [2:0] {
        EV_READ     = 3'd0,
        EV_STORED   = 3'd1,
        EV_SYNC     = 3'd2,
        EV_LENERR   = 3'd3,
        EV_OVERFLOW = 3'd4,
        EV_DONE     = 3'd5
    } evt_code_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    typedef struct packed {
        evt_code_t        evt;
        logic [CNT_W-1:0] len;
        logic             rd_hit;
    } beat_res_t;

    function automatic logic [7:0] sync_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0: b = SYNC_B0;
            2'd1: b = SYNC_B1;
            2'd2: b = SYNC_B2;
            2'd3: b = SYNC_B3;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/swld_store.sv]
// Frame byte buffer: one synchronous RAM, one write or one read per cycle.
// Depends on swld_pkg for the request struct and address width.
`default_nettype none

module swld_store
    import swld_pkg::*;
(
    input  wire logic     aclk,
    input  wire mem_req_t req,
    output logic [7:0]    rd_data
);

    logic [7:0] store_mem [BUFFER_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            store_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= store_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/swld_ctrl.sv]
// Deframer control: sync hunt, byte counter, length parse and buffer requests.
// Depends on swld_pkg and the assertion macro header.
`default_nettype none
`include "sync_word_length_deframer_macros.svh"

module swld_ctrl
    import swld_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [MAXLEN_W-1:0] cfg_wr_data,
    input  wire logic                accept,
    input  wire logic                cmd,
    input  wire logic [7:0]          rx_byte,
    input  wire logic [IDX_W-1:0]    read_index,
    output mem_req_t                 req,
    output beat_res_t                res
);

    logic [MAXLEN_W-1:0] max_payload_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    expect_reg, expect_next;
    logic [7:0]          len_hi_reg, len_lo_reg;

    logic [CNT_W-1:0] count_inc;
    logic [15:0]      payload;
    logic             sync_miss;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
            count_reg       <= '0;
            expect_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                max_payload_reg <= cfg_wr_data;
            end
            if (accept) begin
                count_reg  <= count_next;
                expect_reg <= expect_next;
            end
        end
    end

    // shadow the length bytes as they are written
    always_ff @(posedge aclk) begin
        if (req.wr_en && (count_reg == CNT_W'(LEN_HI_POS)) && !sync_miss) begin
            len_hi_reg <= rx_byte;
        end
        if (req.wr_en && (count_reg == CNT_W'(LEN_LO_POS)) && !sync_miss) begin
            len_lo_reg <= rx_byte;
        end
    end

    assign count_inc = count_reg + CNT_W'(1);
    assign payload   = {len_hi_reg, len_lo_reg};
    assign sync_miss = (count_reg < CNT_W'(SYNC_BYTES))
                       && (rx_byte != sync_byte(count_reg[1:0]));

    always_comb begin
        count_next  = count_reg;
        expect_next = expect_reg;
        req         = '0;
        res.evt     = EV_STORED;
        res.len     = '0;
        res.rd_hit  = 1'b0;

        if (accept) begin
            if (cmd) begin
                res.evt     = EV_READ;
                res.rd_hit  = (32'(read_index) < BUFFER_BYTES);
                req.rd_en   = 1'b1;
                req.rd_addr = ADDR_W'(read_index);
            end else if (sync_miss) begin
                res.evt     = EV_SYNC;
                expect_next = '0;
                if (rx_byte == SYNC_B0) begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = '0;
                    req.wr_data = rx_byte;
                    count_next  = CNT_W'(1);
                end else begin
                    count_next = '0;
                end
            end else if (32'(count_reg) >= BUFFER_BYTES) begin
                res.evt     = EV_OVERFLOW;
                count_next  = '0;
                expect_next = '0;
            end else begin
                req.wr_en   = 1'b1;
                req.wr_addr = ADDR_W'(count_reg);
                req.wr_data = rx_byte;
                count_next  = count_inc;
                if (count_inc == CNT_W'(HEADER_BYTES)) begin
                    if ((payload == 16'd0) || (payload > 16'(max_payload_reg))) begin
                        res.evt     = EV_LENERR;
                        count_next  = '0;
                        expect_next = '0;
                    end else begin
                        expect_next = CNT_W'(HEADER_BYTES + CRC_BYTES)
                                      + CNT_W'(payload[MAXLEN_W-1:0]);
                    end
                end
                if ((res.evt == EV_STORED) && (expect_next != '0)
                    && (count_inc == expect_next)) begin
                    res.evt     = EV_DONE;
                    res.len     = count_inc;
                    count_next  = '0;
                    expect_next = '0;
                end
            end
        end
    end

    `SWLD_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, 32'(count_reg) <= BUFFER_BYTES, "count past buffer")
    `SWLD_ASSERT_ALWAYS(a_expect_span, aclk, aresetn, (expect_reg == '0) || ((count_reg >= CNT_W'(HEADER_BYTES)) && (count_reg < expect_reg)), "expected total out of step with count")
    `SWLD_ASSERT_NEXT(a_done_clears, aclk, aresetn, accept && (res.evt == EV_DONE), (count_reg == '0) && (expect_reg == '0), "counters not cleared after frame")

endmodule

`default_nettype wire

[rtl/sync_word_length_deframer.sv]
// Sync word length deframer: hunts for the sync word "MFP1", buffers the frame,
// parses the big-endian payload length and reports each beat's outcome.
// Channels: s_ carries received bytes (s_tuser 0) or buffer reads (s_tuser 1);
// each accepted input beat yields exactly one m_ beat, in order.
// m_tuser gives the outcome: read reply, byte stored, sync discard, length
// error, overflow or frame complete; m_tdata carries frame length and read data.
// cfg_wr_en/cfg_wr_data set the largest accepted payload length; the user writes it
// only while idle, which the block does not enforce. An input beat passes the read
// stage, then the output register, to m_. Throughput: one beat per cycle unless m_
// stalls; the buffer RAM takes one access per beat and its registered read port sets
// the two-stage pipeline. Reset (aresetn low, synchronous) clears counters, pipeline
// and sets the payload limit to 2036; the buffer keeps its contents and is not cleared.
// A stalled m_tready holds the output beat; one more beat waits in the
// read stage, after which s_tready drops until the output drains.
// The host must read a completed frame before new bytes overwrite it; the block
// does not enforce this. Depends on swld_pkg, swld_ctrl, swld_store and the macro header.
`default_nettype none
`include "sync_word_length_deframer_macros.svh"

module sync_word_length_deframer
    import swld_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // rx_byte[7:0], read_index[18:8], zero fill
    input  wire logic        s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // frame_length[11:0], read_data[19:12], zero fill
    output logic [2:0]       m_tuser    // event_res
);

    logic      accept;
    mem_req_t  mem_req;
    beat_res_t ctrl_res;
    logic [7:0] rd_data;

    logic      st1_valid_reg;
    beat_res_t st1_res_reg;
    logic      out_valid_reg;
    evt_code_t out_evt_reg;
    logic [CNT_W-1:0] out_len_reg;
    logic [7:0] out_data_reg;
    logic      out_load;

    assign out_load = st1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st1_valid_reg || !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    swld_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .cmd         (s_tuser),
        .rx_byte     (s_tdata[7:0]),
        .read_index  (s_tdata[18:8]),
        .req         (mem_req),
        .res         (ctrl_res)
    );

    swld_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                st1_valid_reg <= 1'b1;
            end else if (out_load) begin
                st1_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_res_reg <= ctrl_res;
        end
        if (out_load) begin
            out_evt_reg  <= st1_res_reg.evt;
            out_len_reg  <= st1_res_reg.len;
            out_data_reg <= st1_res_reg.rd_hit ? rd_data : 8'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_evt_reg;
    assign m_tdata  = {4'd0, out_data_reg, out_len_reg};

    `SWLD_ASSERT_ALWAYS(a_no_overrun, aclk, aresetn, !(st1_valid_reg && m_tvalid && !m_tready && s_tready), "input taken with both stages full")
    `SWLD_ASSERT_ALWAYS(a_data_only_read, aclk, aresetn, !m_tvalid || (m_tuser == EV_READ) || (m_tdata[19:12] == 8'd0), "read data on a non-read beat")
    `SWLD_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output beat changed under stall")

endmodule

`default_nettype wire

[tb/deframer_checker.sv]
`timescale 1ns / 100ps
// Checker for the sync word length deframer: watches the config port and both streams,
// predicts each input beat's outcome and compares it with the output beat. Uses swld_pkg.

module deframer_checker
    import swld_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [10:0]             cfg_wr_data,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tready,
    input  wire logic [23:0]             s_tdata,   // rx_byte[7:0], read_index[18:8], zero fill
    input  wire logic                    s_tuser,   // cmd
    input  wire logic                    m_tvalid,
    input  wire logic                    m_tready,
    input  wire logic [23:0]             m_tdata,   // frame_length[11:0], read_data[19:12], zero fill
    input  wire logic [2:0]              m_tuser,   // event_res
    output int                           fail_count,
    output int                           pending,
    output logic [BUFFER_BYTES-1:0]      slot_written
);

    localparam logic [31:0] SYNC_WORD = {SYNC_B3, SYNC_B2, SYNC_B1, SYNC_B0};

    typedef struct packed {
        evt_code_t        evt;
        logic [CNT_W-1:0] len;
        logic [7:0]       data;
    } outcome_t;

    outcome_t            expected_outcomes[$];
    logic [7:0]          frame_bytes [BUFFER_BYTES];
    logic [MAXLEN_W-1:0] max_len;
    int                  rx_count;
    int                  total_len;
    int                  evt_seen [6];
    int                  beats_checked;
    int                  cfg_writes;

    initial begin
        fail_count    = 0;
        pending       = 0;
        slot_written  = '0;
        rx_count      = 0;
        total_len     = 0;
        max_len       = MAX_PAYLOAD_RESET;
        beats_checked = 0;
        cfg_writes    = 0;
        for (int i = 0; i < 6; i++) evt_seen[i] = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic outcome_t deframe_predict(input logic cmd, input logic [7:0] b,
                                                 input logic [IDX_W-1:0] idx);
        outcome_t r;
        int       payload;
        r.evt  = EV_STORED;
        r.len  = '0;
        r.data = '0;
        if (cmd) begin
            r.evt  = EV_READ;
            r.data = frame_bytes[idx];
        end else if (rx_count < SYNC_BYTES && b != SYNC_WORD[8*rx_count +: 8]) begin
            r.evt     = EV_SYNC;
            total_len = 0;
            if (b == SYNC_B0) begin
                frame_bytes[0]  = b;
                slot_written[0] = 1'b1;
                rx_count        = 1;
            end else begin
                rx_count = 0;
            end
        end else if (rx_count >= BUFFER_BYTES) begin
            r.evt     = EV_OVERFLOW;
            rx_count  = 0;
            total_len = 0;
        end else begin
            frame_bytes[rx_count]  = b;
            slot_written[rx_count] = 1'b1;
            rx_count++;
            if (rx_count == HEADER_BYTES) begin
                payload = {frame_bytes[LEN_HI_POS], frame_bytes[LEN_LO_POS]};
                if (payload == 0 || payload > max_len) begin
                    r.evt     = EV_LENERR;
                    rx_count  = 0;
                    total_len = 0;
                end else begin
                    total_len = HEADER_BYTES + payload + CRC_BYTES;
                end
            end
            if (r.evt == EV_STORED && total_len != 0 && rx_count == total_len) begin
                r.evt     = EV_DONE;
                r.len     = CNT_W'(rx_count);
                rx_count  = 0;
                total_len = 0;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            rx_count  = 0;
            total_len = 0;
            max_len   = MAX_PAYLOAD_RESET;
        end else begin
            if (cfg_wr_en) begin
                max_len = cfg_wr_data;
                cfg_writes++;
            end
            if (s_tvalid && s_tready)
                expected_outcomes.push_back(deframe_predict(s_tuser, s_tdata[7:0], s_tdata[18:8]));
            if (m_tvalid && m_tready) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("result beat with nothing pending, event", m_tuser, -1);
                end else begin
                    want = expected_outcomes.pop_front();
                    beats_checked++;
                    evt_seen[want.evt]++;
                    if (m_tuser !== want.evt)
                        report_mismatch("event_res", m_tuser, want.evt);
                    if (m_tdata[11:0] !== want.len)
                        report_mismatch("frame_length", m_tdata[11:0], want.len);
                    if (m_tdata[19:12] !== want.data)
                        report_mismatch("read_data", m_tdata[19:12], want.data);
                end
            end
            pending = expected_outcomes.size();
        end
    end

    task automatic close_out();
        if (expected_outcomes.size() != 0)
            report_mismatch("results never delivered, count", 0, expected_outcomes.size());
    endtask

    task automatic print_summary();
        $display("Run covered %0d beats: %0d frames complete, %0d reads, %0d bytes stored,",
                 beats_checked, evt_seen[EV_DONE], evt_seen[EV_READ], evt_seen[EV_STORED]);
        $display("%0d sync discards, %0d length errors, %0d overflows, %0d limit writes.",
                 evt_seen[EV_SYNC], evt_seen[EV_LENERR], evt_seen[EV_OVERFLOW], cfg_writes);
    endtask

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, stimulus, receiver back-pressure and verdict.
// Depends on swld_pkg, the sync_word_length_deframer RTL and deframer_checker.

module testbench;
    import swld_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 200;
    localparam int DRAIN_LIMIT  = 10000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [10:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    int                      fail_count;
    int                      pending;
    logic [BUFFER_BYTES-1:0] slot_written;

    logic hold_req = 1'b0;
    bit   tx_gaps;
    bit   rx_gaps;
    int   items_sent;
    int   max_setting;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sync_word_length_deframer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    deframer_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .slot_written (slot_written)
    );

    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(input logic cmd, input logic [7:0] rx_byte,
                             input logic [IDX_W-1:0] rd_idx);
        int gap;
        gap = pick_gap(tx_gaps);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, rd_idx, rx_byte};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        logic [IDX_W-1:0] junk_idx;
        junk_idx = IDX_W'($urandom);
        send_beat(1'b0, b, junk_idx);
    endtask

    task automatic send_read_at(input logic [IDX_W-1:0] idx);
        logic [7:0] junk_byte;
        junk_byte = 8'($urandom);
        send_beat(1'b1, junk_byte, idx);
    endtask

    // pick a slot already written; skip the read if none is
    task automatic send_read();
        logic [IDX_W-1:0] idx;
        int               tries;
        idx   = IDX_W'($urandom_range(0, 1) ? $urandom_range(0, 47) : $urandom);
        tries = 0;
        while (!slot_written[idx] && tries < BUFFER_BYTES) begin
            idx = idx + 1'b1;
            tries++;
        end
        if (slot_written[idx])
            send_read_at(idx);
    endtask

    task automatic send_frame(input int plen, input int body, input int read_pct);
        logic [7:0] hdr [HEADER_BYTES];
        hdr[0] = SYNC_B0;
        hdr[1] = SYNC_B1;
        hdr[2] = SYNC_B2;
        hdr[3] = SYNC_B3;
        hdr[4] = 8'($urandom);
        hdr[5] = plen[15:8];
        hdr[6] = plen[7:0];
        hdr[7] = 8'($urandom);
        for (int i = 0; i < HEADER_BYTES; i++) begin
            send_rx(hdr[i]);
            if ($urandom_range(0, 99) < read_pct) send_read();
        end
        for (int i = 0; i < body; i++) begin
            send_rx(8'($urandom));
            if ($urandom_range(0, 99) < read_pct) send_read();
        end
    endtask

    task automatic send_random_frame();
        int r;
        int lim;
        int plen;
        int body;
        r   = $urandom_range(0, 99);
        lim = (max_setting < 1) ? 24 : ((max_setting < 24) ? max_setting : 24);
        if (r < 80 || (max_setting > 64 && r < 94))
            plen = $urandom_range(1, lim);
        else if (r < 87)
            plen = max_setting;
        else if (r < 94)
            plen = max_setting + 1;
        else if (r < 97)
            plen = 0;
        else
            plen = $urandom_range(BUFFER_BYTES, 65535);
        if (plen >= 1 && plen <= max_setting)
            body = ($urandom_range(0, 9) == 0) ? $urandom_range(0, plen + 3) : plen + CRC_BYTES;
        else
            body = $urandom_range(0, 6);
        send_frame(plen, body, 8);
    endtask

    // mix plain noise with pieces of the sync word to break the hunt midway
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0:       send_rx(SYNC_B0);
                1:       send_rx(SYNC_B1);
                2:       send_rx(SYNC_B2);
                3:       send_rx(SYNC_B3);
                default: send_rx(8'($urandom));
            endcase
        end
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int r;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_random_frame();
            else if (r < 85)
                send_noise();
            else
                repeat ($urandom_range(1, 3)) send_read();
        end
    endtask

    task automatic wait_drained();
        int guard;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (pending != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_max_payload(input logic [10:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        max_setting = int'(value);
    endtask

    // receiver: random ready windows, plus one long hold on request
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = pick_gap(rx_gaps);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        tx_gaps     = 1'b1;
        rx_gaps     = 1'b1;
        items_sent  = 0;
        max_setting = MAX_PAYLOAD_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // hunt: garbage, repeated first sync byte, broken sync words
        send_rx(8'hFF);
        send_rx(8'h00);
        send_rx(SYNC_B0);
        send_frame(1, 1 + CRC_BYTES, 0);
        send_rx(SYNC_B0);
        send_rx(SYNC_B1);
        send_rx(SYNC_B0);
        send_rx(SYNC_B1);
        send_rx(SYNC_B2);
        send_rx(8'h00);
        send_read_at(11'd0);
        send_read_at(11'd12);
        send_frame(0, 0, 0);

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        set_max_payload(11'd0);
        send_frame(1, 1 + CRC_BYTES, 0);
        set_max_payload(11'd100);
        send_frame(101, 0, 0);
        send_frame(100, 100 + CRC_BYTES, 5);
        send_frame(16'hFFFF, 2, 0);

        set_max_payload(11'd16);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_random(PHASE_ITEMS);

        set_max_payload(11'($urandom_range(1, 64)));
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        hold_req <= 1'b1;
        run_random(PHASE_ITEMS);

        set_max_payload(MAX_PAYLOAD_RESET);
        rx_gaps = 1'b0;
        run_random(PHASE_ITEMS);

        set_max_payload(11'd1);
        tx_gaps = 1'b0;
        rx_gaps = 1'b1;
        run_random(PHASE_ITEMS);

        wait_drained();
        u_check.close_out();
        u_check.print_summary();
        @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/swld_pkg.sv
rtl/swld_store.sv
rtl/swld_ctrl.sv
rtl/sync_word_length_deframer.sv
tb/deframer_checker.sv
tb/testbench.sv
